### sv/ycc_pkg.sv
package ycc_pkg;

	// pixel and byte widths
	localparam int PIX_W = 32;
	localparam int BYTE_W = 8;

	// narrow signed width for byte products, chroma offsets and weighted sums
	localparam int P_W = 27;
	// accumulator width for Q32 byte-unit values
	localparam int ACC_W = 44;
	// full product width of two narrow operands
	localparam int PROD_W = 2 * P_W;

	// chroma scale and offset, Q16
	localparam logic signed [P_W-1:0] CH_FACTOR = P_W'(65793);
	localparam logic signed [P_W-1:0] CH_OFFSET = P_W'(8421500);

	// decode matrix, Q16
	localparam logic signed [P_W-1:0] K_RCR = P_W'(103206);
	localparam logic signed [P_W-1:0] K_GCR = P_W'(30677);
	localparam logic signed [P_W-1:0] K_GCB = P_W'(12275);
	localparam logic signed [P_W-1:0] K_BCB = P_W'(121609);

	// encode matrix, Q16
	localparam logic signed [P_W-1:0] K_YR = P_W'(13933);
	localparam logic signed [P_W-1:0] K_YG = P_W'(46872);
	localparam logic signed [P_W-1:0] K_YB = P_W'(4731);
	localparam logic signed [P_W-1:0] K_CBR = P_W'(-7508);
	localparam logic signed [P_W-1:0] K_CBG = P_W'(-25260);
	localparam logic signed [P_W-1:0] K_CBB = P_W'(32768);
	localparam logic signed [P_W-1:0] K_CRR = P_W'(32768);
	localparam logic signed [P_W-1:0] K_CRG = P_W'(-29764);
	localparam logic signed [P_W-1:0] K_CRB = P_W'(-3004);
	localparam logic signed [P_W-1:0] K_INVF = P_W'(65280);

	// direction codes
	typedef enum logic {
		DIR_DECODE = 1'b0,
		DIR_ENCODE = 1'b1
	} ycc_dir_t;

	// control into the conversion pipeline
	typedef struct packed {
		logic     in_valid;
		logic     out_ready;
		ycc_dir_t dir;
	} ycc_ctl_t;

	// status out of the conversion pipeline
	typedef struct packed {
		logic in_ready;
		logic out_valid;
	} ycc_sts_t;

	// zero-extend a byte into the narrow signed width
	function automatic logic signed [P_W-1:0] ext8(input logic [BYTE_W-1:0] v);
		ext8 = $signed(P_W'(v));
	endfunction

	// Q32 byte units: negative gives 0, otherwise truncate and saturate at 255
	function automatic logic [BYTE_W-1:0] clamp_q32(input logic signed [ACC_W-1:0] acc);
		logic [BYTE_W-1:0] res;
		if (acc[ACC_W-1]) begin
			res = '0;
		end else if (|acc[ACC_W-2:32+BYTE_W]) begin
			res = '1;
		end else begin
			res = acc[32+BYTE_W-1:32];
		end
		clamp_q32 = res;
	endfunction

endpackage

### sv/ycc_core.sv
module ycc_core
	import ycc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  ycc_ctl_t         ctl,
	output ycc_sts_t         sts,
	input  logic [PIX_W-1:0] in_data,
	output logic [PIX_W-1:0] out_data
);

	// stage valid bits
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	// stage 1: unpacked bytes, chroma offsets, encode products
	ycc_dir_t                dir_s1;
	logic [BYTE_W-1:0]       y_s1, a_s1;
	logic signed [P_W-1:0]   cbp_s1, crp_s1;
	logic signed [P_W-1:0]   p_s1 [9];

	// stage 2: decode products, encode sums
	ycc_dir_t                dir_s2;
	logic [BYTE_W-1:0]       y_s2, a_s2;
	logic signed [ACC_W-1:0] dr_s2, dg1_s2, dg2_s2, db_s2;
	logic signed [P_W-1:0]   ey_s2, ecb_s2, ecr_s2;

	// stage 3: three Q32 accumulators
	ycc_dir_t                dir_s3;
	logic [BYTE_W-1:0]       a_s3;
	logic signed [ACC_W-1:0] c0_s3, c1_s3, c2_s3;

	// stage 4: packed output
	logic [PIX_W-1:0]        out_s4;

	// ready chain, a stage moves when it is empty or the next one moves
	always_comb begin
		rdy4 = !v_s4 || ctl.out_ready;
		rdy3 = !v_s3 || rdy4;
		rdy2 = !v_s2 || rdy3;
		rdy1 = !v_s1 || rdy2;
	end

	assign sts.in_ready  = rdy1;
	assign sts.out_valid = v_s4;
	assign out_data      = out_s4;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= ctl.in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// stage 1 datapath
	logic [BYTE_W-1:0] b0, b1, b2, b3;
	assign b0 = in_data[7:0];
	assign b1 = in_data[15:8];
	assign b2 = in_data[23:16];
	assign b3 = in_data[31:24];

	always_ff @(posedge clk) begin
		if (rdy1 && ctl.in_valid) begin
			dir_s1 <= ctl.dir;
			y_s1   <= b0;
			// alpha sits in byte 1 for decode and byte 3 for encode
			a_s1   <= (ctl.dir == DIR_ENCODE) ? b3 : b1;
			cbp_s1 <= P_W'(ext8(b2) * CH_FACTOR - CH_OFFSET);
			crp_s1 <= P_W'(ext8(b3) * CH_FACTOR - CH_OFFSET);
			p_s1[0] <= P_W'(ext8(b0) * K_YR);
			p_s1[1] <= P_W'(ext8(b1) * K_YG);
			p_s1[2] <= P_W'(ext8(b2) * K_YB);
			p_s1[3] <= P_W'(ext8(b0) * K_CBR);
			p_s1[4] <= P_W'(ext8(b1) * K_CBG);
			p_s1[5] <= P_W'(ext8(b2) * K_CBB);
			p_s1[6] <= P_W'(ext8(b0) * K_CRR);
			p_s1[7] <= P_W'(ext8(b1) * K_CRG);
			p_s1[8] <= P_W'(ext8(b2) * K_CRB);
		end
	end

	// stage 2 datapath, decode matrix products
	logic signed [PROD_W-1:0] m_r, m_g1, m_g2, m_b;
	always_comb begin
		m_r  = PROD_W'(crp_s1) * PROD_W'(K_RCR);
		m_g1 = PROD_W'(crp_s1) * PROD_W'(K_GCR);
		m_g2 = PROD_W'(cbp_s1) * PROD_W'(K_GCB);
		m_b  = PROD_W'(cbp_s1) * PROD_W'(K_BCB);
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			dir_s2 <= dir_s1;
			y_s2   <= y_s1;
			a_s2   <= a_s1;
			dr_s2  <= ACC_W'(m_r);
			dg1_s2 <= ACC_W'(m_g1);
			dg2_s2 <= ACC_W'(m_g2);
			db_s2  <= ACC_W'(m_b);
			ey_s2  <= p_s1[0] + p_s1[1] + p_s1[2];
			ecb_s2 <= p_s1[3] + p_s1[4] + p_s1[5] + CH_OFFSET;
			ecr_s2 <= p_s1[6] + p_s1[7] + p_s1[8] + CH_OFFSET;
		end
	end

	// stage 3 datapath, luma sums for decode, rescale for encode
	logic signed [ACC_W-1:0]  y32;
	logic signed [PROD_W-1:0] m_cb, m_cr;
	always_comb begin
		y32  = $signed(ACC_W'(y_s2)) <<< 32;
		m_cb = PROD_W'(ecb_s2) * PROD_W'(K_INVF);
		m_cr = PROD_W'(ecr_s2) * PROD_W'(K_INVF);
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			dir_s3 <= dir_s2;
			a_s3   <= a_s2;
			unique case (dir_s2)
				DIR_DECODE: begin
					c0_s3 <= y32 + dr_s2;
					c1_s3 <= y32 - dg1_s2 - dg2_s2;
					c2_s3 <= y32 + db_s2;
				end
				DIR_ENCODE: begin
					c0_s3 <= ACC_W'(ey_s2) <<< 16;
					c1_s3 <= ACC_W'(m_cb);
					c2_s3 <= ACC_W'(m_cr);
				end
				default: begin
					c0_s3 <= '0;
					c1_s3 <= '0;
					c2_s3 <= '0;
				end
			endcase
		end
	end

	// stage 4 datapath, clamp and pack
	logic [BYTE_W-1:0] q0, q1, q2;
	always_comb begin
		q0 = clamp_q32(c0_s3);
		q1 = clamp_q32(c1_s3);
		q2 = clamp_q32(c2_s3);
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			unique case (dir_s3)
				DIR_DECODE: out_s4 <= {a_s3, q2, q1, q0};
				DIR_ENCODE: out_s4 <= {q2, q1, a_s3, q0};
				default:    out_s4 <= '0;
			endcase
		end
	end

endmodule

### sv/ycbcr_rgba_color_converter_unit.sv
// throughput: one pixel per cycle unless m_axis_tready stalls it, through a
//   four-stage pipeline (stage 1 to 4 registers), set by the constant
//   multipliers and the sums between each pair of stage registers
// reset: arst_n clears all stage valid bits and sets direction to decode;
//   the configuration channel is always ready
module ycbcr_rgba_color_converter_unit
	import ycc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// configuration write: direction
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_data,
	// input pixel stream
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [PIX_W-1:0] s_axis_tdata,   // pixel_in[31:0]
	// output pixel stream
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [PIX_W-1:0] m_axis_tdata    // pixel_out[31:0]
);

	ycc_dir_t dir_q;
	ycc_ctl_t ctl;
	ycc_sts_t sts;

	// direction register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_DECODE;
		end else if (cfg_valid && cfg_ready) begin
			dir_q <= ycc_dir_t'(cfg_data);
		end
	end

	// conversion pipeline
	always_comb begin
		ctl.in_valid  = s_axis_tvalid;
		ctl.out_ready = m_axis_tready;
		ctl.dir       = dir_q;
	end

	ycc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sts      (sts),
		.in_data  (s_axis_tdata),
		.out_data (m_axis_tdata)
	);

	assign s_axis_tready = sts.in_ready;
	assign m_axis_tvalid = sts.out_valid;

endmodule

### sv/ycc_checker.sv
module ycc_checker
	import ycc_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             cfg_valid,
	input logic             cfg_ready,
	input logic             cfg_data,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic [PIX_W-1:0] s_axis_tdata,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [PIX_W-1:0] m_axis_tdata
);

	// a stalled output beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output beat dropped while stalled");

	// a stalled output beat keeps its data
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output data changed while stalled");

	// an empty output stage means the whole pipeline can move
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with output stage empty");

	// direction writes are never back-pressured
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind ycbcr_rgba_color_converter_unit ycc_checker u_chk (.*);
